/* hw/rtl/rsmp_pkg.sv */
package rsmp_pkg;

    localparam int MAX_TAPS   = 512;
    localparam int MAX_PHASES = 256;
    localparam int MAX_RUN    = 8;
    localparam int COEF_DEPTH = MAX_TAPS * MAX_PHASES;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int HIST_AW    = $clog2(MAX_TAPS);
    localparam int TAP_W      = 10;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 34;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);
    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 2;

    typedef enum logic {
        OP_COEF  = 1'b0,
        OP_FRAME = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_TAP_COUNT   = 2'd0,
        REG_PHASE_COUNT = 2'd1,
        REG_INT_ADV     = 2'd2,
        REG_FRAC_ADV    = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_MAC,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [16:0]        addr;
        logic signed [17:0] coef;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } cmd_t;

    typedef struct packed {
        logic [TAP_W-1:0] taps;
        logic [8:0]       phase_count;
        logic [4:0]       int_adv;
        logic [7:0]       frac_adv;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
        logic               overrun;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic push;
    } back_status_t;

endpackage

/* hw/rtl/rsmp_ram.sv */
module rsmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/rsmp_front.sv */
module rsmp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  operation,
    input  logic [16:0]           coef_address,
    input  logic signed [17:0]    coef_value,
    input  logic signed [15:0]    left_sample,
    input  logic signed [15:0]    right_sample,
    input  logic                  clearing,
    input  logic                  cmd_pop,
    output logic                  cmd_empty,
    output rsmp_pkg::cmd_t        cmd_head
);

    localparam int QAW = $clog2(rsmp_pkg::CMDQ_DEPTH);

    rsmp_pkg::cmd_t entry_reg [rsmp_pkg::CMDQ_DEPTH];
    logic [QAW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    rsmp_pkg::cmd_t word;
    logic           accept;

    // Tag each word as a coefficient load or a frame.
    always_comb
    begin
        word.op    = operation ? rsmp_pkg::OP_FRAME : rsmp_pkg::OP_COEF;
        word.addr  = coef_address;
        word.coef  = coef_value;
        word.left  = left_sample;
        word.right = right_sample;
    end

    assign full      = (cnt_reg == (QAW+1)'(rsmp_pkg::CMDQ_DEPTH)) || clearing;
    assign accept    = push && !full;
    assign cmd_empty = (cnt_reg == '0);
    assign cmd_head  = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = accept ? wr_reg + 1'b1 : wr_reg;
        rd_next  = cmd_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QAW+1)'(accept) - (QAW+1)'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_reg] <= word;
        end
    end

endmodule

/* hw/rtl/rsmp_back.sv */
module rsmp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsmp_pkg::cfg_t          cfg,
    input  logic                    cmd_empty,
    input  rsmp_pkg::cmd_t          cmd_head,
    output logic                    cmd_pop,
    input  logic                    res_space,
    output rsmp_pkg::result_t       res_word,
    output rsmp_pkg::back_status_t  status
);

    localparam int HAW = rsmp_pkg::HIST_AW;
    localparam int CAW = rsmp_pkg::COEF_AW;
    localparam int TW  = rsmp_pkg::TAP_W;
    localparam int AW  = rsmp_pkg::ACC_W;
    localparam int PW  = rsmp_pkg::PROD_W;
    localparam int RW  = rsmp_pkg::RUN_W;

    rsmp_pkg::back_state_t state_reg, state_next;

    logic [HAW-1:0]       clr_reg, clr_next;
    logic [HAW-1:0]       wp_reg, wp_next;
    logic signed [5:0]    lead_reg, lead_next;
    logic [7:0]           phase_reg, phase_next;
    logic [RW-1:0]        run_reg, run_next;
    logic [TW-1:0]        k_reg, k_next;
    logic [CAW-1:0]       base_reg, base_next;
    logic                 v1_reg, v2_reg;
    logic signed [PW-1:0] prod_l_reg, prod_r_reg;
    logic signed [AW-1:0] acc_l_reg, acc_l_next, acc_r_reg, acc_r_next;

    logic                 hist_we, coef_we, issue, frame_due;
    logic [HAW-1:0]       hist_waddr, hist_raddr;
    logic [31:0]          hist_wdata, hist_rdata;
    logic [CAW-1:0]       coef_raddr;
    logic [17:0]          coef_rdata;
    logic [8:0]           phase_sum, phase_wrapped;
    logic                 carry, cont;
    logic [5:0]           step;
    logic signed [5:0]    lead_after;

    function automatic logic signed [15:0] round_sat(input logic signed [AW-1:0] acc);
        logic signed [AW:0]   t;
        logic signed [AW-17:0] r;
        t = {acc[AW-1], acc} + (AW+1)'(65536);
        r = t[AW:17];
        if (r > (AW-16)'(32767))
            round_sat = 16'sd32767;
        else if (r < -(AW-16)'(32768))
            round_sat = -16'sd32768;
        else
            round_sat = r[15:0];
    endfunction

    rsmp_ram #(.WIDTH(32), .DEPTH(rsmp_pkg::MAX_TAPS)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    rsmp_ram #(.WIDTH(18), .DEPTH(rsmp_pkg::COEF_DEPTH)) u_coef (
        .clk   (clk),
        .we    (coef_we),
        .waddr (cmd_head.addr[CAW-1:0]),
        .wdata (cmd_head.coef),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    assign frame_due  = (cmd_head.op == rsmp_pkg::OP_FRAME) && (lead_reg >= 6'sd0);
    assign issue      = (state_reg == rsmp_pkg::ST_MAC) && (k_reg != cfg.taps);
    assign coef_raddr = base_reg + CAW'(k_reg);
    assign hist_raddr = wp_reg - cfg.taps[HAW-1:0] + k_reg[HAW-1:0];

    // Phase step and the lead left after this output
    always_comb
    begin
        phase_sum     = {1'b0, phase_reg} + {1'b0, cfg.frac_adv};
        carry         = (phase_sum >= cfg.phase_count);
        phase_wrapped = carry ? phase_sum - cfg.phase_count : phase_sum;
        step          = {1'b0, cfg.int_adv} + 6'(carry);
        lead_after    = lead_reg - $signed(step);
        cont          = (lead_after > 6'sd0) && (run_reg != RW'(rsmp_pkg::MAX_RUN - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsmp_pkg::ST_CLEAR:
                if (clr_reg == HAW'(rsmp_pkg::MAX_TAPS - 1))
                    state_next = rsmp_pkg::ST_IDLE;
            rsmp_pkg::ST_IDLE:
                if (!cmd_empty && frame_due)
                    state_next = rsmp_pkg::ST_SETUP;
            rsmp_pkg::ST_SETUP:
                state_next = rsmp_pkg::ST_MAC;
            rsmp_pkg::ST_MAC:
                if (!issue && !v1_reg && !v2_reg)
                    state_next = rsmp_pkg::ST_EMIT;
            rsmp_pkg::ST_EMIT:
                if (res_space)
                    state_next = cont ? rsmp_pkg::ST_SETUP : rsmp_pkg::ST_IDLE;
            default:
                state_next = rsmp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop    = 1'b0;
        hist_we    = 1'b0;
        coef_we    = 1'b0;
        hist_waddr = wp_reg;
        hist_wdata = {cmd_head.left, cmd_head.right};
        status     = '0;
        unique case (state_reg)
            rsmp_pkg::ST_CLEAR:
            begin
                hist_we         = 1'b1;
                hist_waddr      = clr_reg;
                hist_wdata      = '0;
                status.clearing = 1'b1;
            end
            rsmp_pkg::ST_IDLE:
            begin
                cmd_pop = !cmd_empty;
                hist_we = !cmd_empty && (cmd_head.op == rsmp_pkg::OP_FRAME);
                coef_we = !cmd_empty && (cmd_head.op == rsmp_pkg::OP_COEF);
            end
            rsmp_pkg::ST_EMIT:
                status.push = res_space;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_word.left    = round_sat(acc_l_reg);
        res_word.right   = round_sat(acc_r_reg);
        res_word.last    = !cont;
        res_word.overrun = !cont && (lead_after > 6'sd0);
    end

    always_comb
    begin
        clr_next   = clr_reg;
        wp_next    = wp_reg;
        lead_next  = lead_reg;
        phase_next = phase_reg;
        run_next   = run_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        acc_l_next = acc_l_reg;
        acc_r_next = acc_r_reg;
        if (v2_reg)
        begin
            acc_l_next = acc_l_reg + AW'(prod_l_reg);
            acc_r_next = acc_r_reg + AW'(prod_r_reg);
        end
        unique case (state_reg)
            rsmp_pkg::ST_CLEAR:
                clr_next = clr_reg + 1'b1;
            rsmp_pkg::ST_IDLE:
                if (!cmd_empty && cmd_head.op == rsmp_pkg::OP_FRAME)
                begin
                    wp_next   = wp_reg + 1'b1;
                    lead_next = lead_reg + 6'sd1;
                    run_next  = '0;
                end
            rsmp_pkg::ST_SETUP:
            begin
                base_next  = CAW'(phase_reg) * CAW'(cfg.taps);
                k_next     = '0;
                acc_l_next = '0;
                acc_r_next = '0;
            end
            rsmp_pkg::ST_MAC:
                if (issue)
                    k_next = k_reg + 1'b1;
            rsmp_pkg::ST_EMIT:
                if (res_space)
                begin
                    phase_next = phase_wrapped[7:0];
                    run_next   = run_reg + 1'b1;
                    // drop the outputs still due after a full run
                    lead_next  = (!cont && lead_after > 6'sd0) ? 6'sd0 : lead_after;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsmp_pkg::ST_CLEAR;
            clr_reg   <= '0;
            wp_reg    <= '0;
            lead_reg  <= '0;
            phase_reg <= '0;
            run_reg   <= '0;
            k_reg     <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            wp_reg    <= wp_next;
            lead_reg  <= lead_next;
            phase_reg <= phase_next;
            run_reg   <= run_next;
            k_reg     <= k_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        acc_l_reg  <= acc_l_next;
        acc_r_reg  <= acc_r_next;
        prod_l_reg <= $signed(coef_rdata) * $signed(hist_rdata[31:16]);
        prod_r_reg <= $signed(coef_rdata) * $signed(hist_rdata[15:0]);
    end

endmodule

/* hw/rtl/polyphase_stereo_resampler.sv */
// A frame waits in the command queue while earlier frames are worked on; each output then passes
// SETUP, MAC and EMIT, one multiply-accumulate per tap for both channels, set by the coefficient RAM port.
// Coefficient words are taken one per cycle while the back end is idle and the queue has room.
// Reset is asynchronous, active low; after it the history ring is
// zeroed, during which full stays high. Coefficients survive reset.
module polyphase_stereo_resampler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               operation,
    input  logic [16:0]        coef_address,
    input  logic signed [17:0] coef_value,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               last,
    output logic               overrun,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data
);

    localparam int OAW = $clog2(rsmp_pkg::OUTQ_DEPTH);
    localparam int TW  = rsmp_pkg::TAP_W;

    // Configuration registers; the user must write them only while the block is idle (not enforced here)
    logic [9:0] tap_reg;
    logic [8:0] pcount_reg;
    logic [4:0] iadv_reg;
    logic [7:0] fadv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg    <= 10'd256;
            pcount_reg <= 9'd1;
            iadv_reg   <= 5'd1;
            fadv_reg   <= 8'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rsmp_pkg::REG_TAP_COUNT:   tap_reg    <= cfg_data;
                rsmp_pkg::REG_PHASE_COUNT: pcount_reg <= cfg_data[8:0];
                rsmp_pkg::REG_INT_ADV:     iadv_reg   <= cfg_data[4:0];
                rsmp_pkg::REG_FRAC_ADV:    fadv_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Drop the low two bits of the tap count and clamp to the history depth.
    rsmp_pkg::cfg_t cfg;
    logic [TW-1:0]  tap_masked;

    always_comb
    begin
        tap_masked      = {tap_reg[9:2], 2'b00};
        cfg.taps        = (tap_masked > TW'(rsmp_pkg::MAX_TAPS)) ?
                          TW'(rsmp_pkg::MAX_TAPS) : tap_masked;
        cfg.phase_count = pcount_reg;
        cfg.int_adv     = iadv_reg;
        cfg.frac_adv    = fadv_reg;
    end

    rsmp_pkg::cmd_t        cmd_head;
    rsmp_pkg::result_t     res_word;
    rsmp_pkg::back_status_t status;
    logic                  cmd_empty, cmd_pop, res_space;

    rsmp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .coef_address (coef_address),
        .coef_value   (coef_value),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .clearing     (status.clearing),
        .cmd_pop      (cmd_pop),
        .cmd_empty    (cmd_empty),
        .cmd_head     (cmd_head)
    );

    rsmp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_space (res_space),
        .res_word  (res_word),
        .status    (status)
    );

    // Result queue: hold finished words until the consumer pops them
    rsmp_pkg::result_t oq_reg [rsmp_pkg::OUTQ_DEPTH];
    logic [OAW-1:0]    owr_reg, ord_reg;
    logic [OAW:0]      ocnt_reg;
    logic              out_pop;

    assign res_space = (ocnt_reg != (OAW+1)'(rsmp_pkg::OUTQ_DEPTH));
    assign empty     = (ocnt_reg == '0);
    assign out_pop   = pop && !empty;
    assign left_out  = oq_reg[ord_reg].left;
    assign right_out = oq_reg[ord_reg].right;
    assign last      = oq_reg[ord_reg].last;
    assign overrun   = oq_reg[ord_reg].overrun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (status.push)
                owr_reg <= owr_reg + 1'b1;
            if (out_pop)
                ord_reg <= ord_reg + 1'b1;
            ocnt_reg <= ocnt_reg + (OAW+1)'(status.push) - (OAW+1)'(out_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.push)
            oq_reg[owr_reg] <= res_word;
    end

    // Never write a result into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) status.push |-> res_space)
        else $error("result queue overflow");

    // No input word may be taken while the history ring is being zeroed.
    assert property (@(posedge clk) disable iff (!rst_n) status.clearing |-> full)
        else $error("input accepted during history clear");

    // An empty result queue stays empty unless the back end writes a word.
    assert property (@(posedge clk) disable iff (!rst_n) (empty && !status.push) |=> empty)
        else $error("result appeared without a write");

endmodule

/* tb/polyphase_stereo_resampler_test.sv */
`timescale 1ns / 1ps

module polyphase_stereo_resampler_test;

    // One word as it goes into the block's input queue.
    typedef struct {
        rsmp_pkg::op_t      op;
        logic [16:0]        addr;
        logic signed [17:0] coef;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } in_word_t;

    // One filtered stereo output as the block should present it.
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
        logic               overrun;
    } out_word_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 600;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               operation = 1'b0;
    logic [16:0]        coef_address = '0;
    logic signed [17:0] coef_value = '0;
    logic signed [15:0] left_sample = '0;
    logic signed [15:0] right_sample = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               last;
    logic               overrun;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [9:0]         cfg_data = '0;

    polyphase_stereo_resampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .coef_address (coef_address),
        .coef_value   (coef_value),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .empty        (empty),
        .pop          (pop),
        .left_out     (left_out),
        .right_out    (right_out),
        .last         (last),
        .overrun      (overrun),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Words still to be sent and outputs still owed by the block.
    in_word_t  send_queue[$];
    out_word_t due_outputs[$];
    int        errors = 0;
    int        send_idle = 16;   // percent of cycles the sender holds back
    int        recv_idle = 60;   // percent of cycles the receiver stalls

    // Shadow of the register file.
    logic [9:0] tap_reg = 10'd256;
    logic [8:0] phase_reg = 9'd1;
    logic [4:0] step_reg = 5'd1;
    logic [7:0] frac_reg = 8'd0;

    // Shadow of the datapath state.
    logic signed [17:0] coef_mem [0:rsmp_pkg::COEF_DEPTH-1];
    logic signed [15:0] hist_l [0:rsmp_pkg::MAX_TAPS-1];
    logic signed [15:0] hist_r [0:rsmp_pkg::MAX_TAPS-1];
    int                 wr_ptr = 0;
    int                 lead = 0;
    logic [7:0]         cur_phase = '0;

    initial begin
        for (int i = 0; i < rsmp_pkg::MAX_TAPS; i++) begin
            hist_l[i] = '0;
            hist_r[i] = '0;
        end
    end

    // Low two bits dropped, clamped to the ring depth.
    function automatic int taps_in_use();
        int n;
        n = int'(tap_reg) & ~3;
        return (n > rsmp_pkg::MAX_TAPS) ? rsmp_pkg::MAX_TAPS : n;
    endfunction

    // Round half up from Q2.32 to Q1.15 and saturate.
    function automatic logic signed [15:0] round_to_q15(input longint acc);
        longint r;
        r = (acc + 64'sd65536) >>> 17;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // Push one frame into the history and queue the outputs now due, at most MAX_RUN of them.
    task automatic resample_frame(input in_word_t w);
        int        n;
        int        count;
        int        age;
        int        pos;
        int        ci;
        int        sum;
        int        carry;
        longint    acc_l;
        longint    acc_r;
        longint    c;
        out_word_t o;
        begin
            n = taps_in_use();
            count = 0;
            hist_l[wr_ptr] = w.left;
            hist_r[wr_ptr] = w.right;
            wr_ptr = (wr_ptr + 1) % rsmp_pkg::MAX_TAPS;
            lead++;
            while (lead > 0 && count < rsmp_pkg::MAX_RUN) begin
                acc_l = 0;
                acc_r = 0;
                for (int k = 0; k < n; k++) begin
                    // age below the newest sample of the tap in this window
                    age = n - 2 + lead - k;
                    age = ((age % rsmp_pkg::MAX_TAPS) + rsmp_pkg::MAX_TAPS)
                          % rsmp_pkg::MAX_TAPS;
                    pos = (wr_ptr + rsmp_pkg::MAX_TAPS - 1 - age) % rsmp_pkg::MAX_TAPS;
                    ci = (int'(cur_phase) * n + k) % rsmp_pkg::COEF_DEPTH;
                    c = coef_mem[ci];
                    acc_l += c * longint'(hist_l[pos]);
                    acc_r += c * longint'(hist_r[pos]);
                end
                o.left = round_to_q15(acc_l);
                o.right = round_to_q15(acc_r);
                o.last = 1'b0;
                o.overrun = 1'b0;
                due_outputs.push_back(o);
                count++;
                // advance the phase; a wrap steps one extra input sample
                sum = int'(cur_phase) + int'(frac_reg);
                carry = 0;
                if (sum >= int'(phase_reg)) begin
                    sum -= int'(phase_reg);
                    carry = 1;
                end
                cur_phase = sum[7:0];
                lead -= int'(step_reg) + carry;
            end
            if (count > 0) begin
                due_outputs[$].last = 1'b1;
                if (lead > 0) begin
                    // too many outputs due: flag it and drop the rest
                    due_outputs[$].overrun = 1'b1;
                    lead = 0;
                end
            end
        end
    endtask

    // Driver: hold a word until it is taken, then offer the next one.
    always @(posedge clk) begin
        in_word_t w;
        logic     taken;
        if (!rst_n) begin
            push <= 1'b0;
        end
        else begin
            taken = push && !full;
            if (taken) begin
                w = send_queue.pop_front();
                if (w.op == rsmp_pkg::OP_COEF)
                    coef_mem[w.addr] = w.coef;
                else
                    resample_frame(w);
            end
            if (!push || taken) begin
                if (send_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    push <= 1'b1;
                    operation <= send_queue[0].op;
                    coef_address <= send_queue[0].addr;
                    coef_value <= send_queue[0].coef;
                    left_sample <= send_queue[0].left;
                    right_sample <= send_queue[0].right;
                end
                else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken output against the oldest one owed.
    always @(posedge clk) begin
        out_word_t e;
        if (rst_n) begin
            if (pop && !empty) begin
                if (due_outputs.size() == 0) begin
                    $display("%0t: output with none owed: %0d %0d last %0b overrun %0b",
                             $time, left_out, right_out, last, overrun);
                    errors++;
                end
                else begin
                    e = due_outputs.pop_front();
                    if (left_out !== e.left) begin
                        $display("%0t: left_out expected %0d, got %0d", $time, e.left, left_out);
                        errors++;
                    end
                    if (right_out !== e.right) begin
                        $display("%0t: right_out expected %0d, got %0d",
                                 $time, e.right, right_out);
                        errors++;
                    end
                    if (last !== e.last) begin
                        $display("%0t: last expected %0b, got %0b", $time, e.last, last);
                        errors++;
                    end
                    if (overrun !== e.overrun) begin
                        $display("%0t: overrun expected %0b, got %0b",
                                 $time, e.overrun, overrun);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog: count cycles in which nothing moves on either port.
    int stuck_cycles = 0;
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || cfg_write || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress, giving up", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input rsmp_pkg::reg_index_t idx, input logic [9:0] value);
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            case (idx)
                rsmp_pkg::REG_TAP_COUNT:   tap_reg = value;
                rsmp_pkg::REG_PHASE_COUNT: phase_reg = value[8:0];
                rsmp_pkg::REG_INT_ADV:     step_reg = value[4:0];
                rsmp_pkg::REG_FRAC_ADV:    frac_reg = value[7:0];
                default:                   ;
            endcase
            @(posedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    task automatic set_config(input logic [9:0] taps, input logic [9:0] phases,
                              input logic [9:0] step, input logic [9:0] frac);
        begin
            write_reg(rsmp_pkg::REG_TAP_COUNT, taps);
            write_reg(rsmp_pkg::REG_PHASE_COUNT, phases);
            write_reg(rsmp_pkg::REG_INT_ADV, step);
            write_reg(rsmp_pkg::REG_FRAC_ADV, frac);
        end
    endtask

    // Wait until every word is taken and every output owed has come, then
    // let the block settle so that a frame with no output has finished too.
    task automatic drain();
        begin
            do
                @(negedge clk);
            while (send_queue.size() > 0 || push || due_outputs.size() > 0);
            repeat (40) @(posedge clk);
        end
    endtask

    function automatic in_word_t frame_word(input logic [15:0] l, input logic [15:0] r);
        in_word_t w;
        w.op = rsmp_pkg::OP_FRAME;
        w.addr = 17'($urandom_range(0, rsmp_pkg::COEF_DEPTH - 1));
        w.coef = 18'($urandom);
        w.left = l;
        w.right = r;
        return w;
    endfunction

    function automatic in_word_t coef_word(input int addr, input logic [17:0] value);
        in_word_t w;
        w.op = rsmp_pkg::OP_COEF;
        w.addr = 17'(addr);
        w.coef = value;
        w.left = 16'($urandom);
        w.right = 16'($urandom);
        return w;
    endfunction

    // Load every coefficient that the phase sequence can reach from the
    // present phase under the present settings, so no unwritten entry is read.
    task automatic load_bank(input bit use_fill, input logic [17:0] fill);
        bit [255:0] reach;
        int         p;
        int         sum;
        int         n;
        begin
            reach = '0;
            p = cur_phase;
            n = taps_in_use();
            repeat (600) begin
                reach[p] = 1'b1;
                sum = p + int'(frac_reg);
                if (sum >= int'(phase_reg))
                    sum -= int'(phase_reg);
                p = sum & 255;
            end
            for (int ph = 0; ph < 256; ph++)
                if (reach[ph])
                    for (int k = 0; k < n; k++)
                        send_queue.push_back(coef_word((ph * n + k) % rsmp_pkg::COEF_DEPTH,
                                                       use_fill ? fill : 18'($urandom)));
        end
    endtask

    // Mostly frames of random content, with stray coefficient writes mixed in.
    task automatic random_words(input int frames);
        int sent;
        begin
            sent = 0;
            while (sent < frames) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_queue.push_back(coef_word(
                        int'($urandom_range(0, rsmp_pkg::COEF_DEPTH - 1)), 18'($urandom)));
                end
                else begin
                    send_queue.push_back(frame_word(16'($urandom), 16'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset phase settings with a short filter: full-scale samples
        // against extreme banks.
        write_reg(rsmp_pkg::REG_TAP_COUNT, 10'd4);
        load_bank(1'b1, 18'sh20000);
        send_queue.push_back(frame_word(16'sh8000, 16'sh8000));
        send_queue.push_back(frame_word(16'sh7fff, 16'sh8000));
        send_queue.push_back(frame_word(16'sh8000, 16'sh7fff));
        send_queue.push_back(frame_word(16'sh0000, 16'sh0000));
        send_queue.push_back(frame_word(16'sh0001, 16'shffff));
        drain();
        load_bank(1'b1, 18'sh1ffff);
        send_queue.push_back(frame_word(16'sh7fff, 16'sh7fff));
        send_queue.push_back(frame_word(16'sh8000, 16'sh0000));
        send_queue.push_back(frame_word(16'sh7fff, 16'sh8000));
        drain();
        load_bank(1'b0, '0);
        random_words(6);
        drain();

        // No advance at all: every frame runs out and flags an overrun.
        set_config(10'd4, 10'd1, 10'd0, 10'd0);
        load_bank(1'b0, '0);
        random_words(8);
        drain();

        send_idle = 60;
        recv_idle = 16;

        // Upsampling by three halves with ignored low tap bits.
        set_config(10'd7, 10'd3, 10'd0, 10'd2);
        load_bank(1'b0, '0);
        random_words(16);
        drain();

        // Downsampling across several phases.
        set_config(10'd4, 10'd5, 10'd2, 10'd3);
        load_bank(1'b0, '0);
        random_words(12);
        drain();

        send_idle = 0;
        recv_idle = 0;

        // Largest phase count: the phase sum runs past eight bits and wraps.
        set_config(10'd4, 10'd256, 10'd0, 10'd192);
        load_bank(1'b0, '0);
        random_words(10);
        drain();

        // Zero taps, zero phase count and an integer advance of 16: mostly no output.
        set_config(10'd3, 10'd0, 10'd16, 10'd255);
        random_words(6);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && due_outputs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
